// ----- hdl/sle_pkg.sv -----
// Package for the sorted list engine: types, codes and sizes.
package sle_pkg;

   localparam int Capacity = 16;
   localparam int IdxWidth = $clog2(Capacity);
   localparam int CntWidth = $clog2(Capacity + 1);

   typedef enum logic [2:0] {
      ACT_INSERT   = 3'd0,
      ACT_REMOVE   = 3'd1,
      ACT_SEARCH   = 3'd2,
      ACT_DUMP_ASC = 3'd3,
      ACT_DUMP_DSC = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] item_value;
      logic [4:0]         entry_count;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DUMP,
      S_SEND
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch_req;   // capture request
      logic do_insert;   // commit insert shift
      logic do_remove;   // commit remove shift
      logic dump_start;  // reset dump index
      logic dump_step;   // advance dump index
      logic load_single; // load single result
      logic load_dump;   // load dump result
   } sle_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] action;
      logic       full;
      logic       empty;
      logic       found;
      logic       dump_last;
   } sle_stat_type;

endpackage

// ----- hdl/sle_datapath.sv -----
// Datapath: chain of entry cells, compare vector, dump index and result register.
module sle_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  sle_pkg::req_type      req_data,
   input  sle_pkg::sle_cmd_type  cmd,
   output sle_pkg::sle_stat_type stat,
   output sle_pkg::rsp_type      rsp_data
);

   logic signed [31:0] cell_ff [sle_pkg::Capacity];
   logic signed [31:0] cell_in [sle_pkg::Capacity];
   logic [sle_pkg::CntWidth-1:0] count_ff, count_in;
   sle_pkg::req_type req_ff;
   logic [sle_pkg::IdxWidth-1:0] didx_ff, didx_in;
   sle_pkg::rsp_type rsp_ff, rsp_in;

   logic [sle_pkg::Capacity-1:0] valid_v, less_v, eq_v, first_eq;

   // per-cell compare, parallel
   always_comb begin
      for (int i = 0; i < sle_pkg::Capacity; i++) begin
         valid_v[i] = (sle_pkg::CntWidth'(i) < count_ff);
         less_v[i]  = valid_v[i] && (cell_ff[i] < req_ff.value);
         eq_v[i]    = valid_v[i] && (cell_ff[i] == req_ff.value);
      end
      first_eq = eq_v & ~(eq_v - 1'b1);
   end

   // shift network: insert at first not-smaller, remove first equal
   always_comb begin
      logic [sle_pkg::Capacity-1:0] after_eq;
      after_eq = ~((first_eq - 1'b1) | first_eq) & ~first_eq;
      for (int i = 0; i < sle_pkg::Capacity; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.do_insert && !less_v[i]) begin
            if (i == 0 || less_v[(i == 0) ? 0 : i - 1])
               cell_in[i] = req_ff.value;
            else
               cell_in[i] = cell_ff[(i == 0) ? 0 : i - 1];
         end
         if (cmd.do_remove && (first_eq[i] || after_eq[i]) &&
             i < sle_pkg::Capacity - 1)
            cell_in[i] = cell_ff[(i < sle_pkg::Capacity - 1) ? i + 1 : i];
      end
      count_in = count_ff;
      if (cmd.do_insert) count_in = count_ff + 1'b1;
      if (cmd.do_remove) count_in = count_ff - 1'b1;
   end

   logic [sle_pkg::IdxWidth-1:0] src_idx, last_idx;
   assign last_idx = sle_pkg::IdxWidth'(count_ff - 1'b1);
   assign src_idx  = (req_ff.action == sle_pkg::ACT_DUMP_ASC) ? didx_ff
                                                              : last_idx - didx_ff;

   always_comb begin
      didx_in = didx_ff;
      if (cmd.dump_start) didx_in = '0;
      else if (cmd.dump_step) didx_in = didx_ff + 1'b1;
      rsp_in = rsp_ff;
      rsp_in.entry_count = 5'(count_in);
      if (cmd.load_single) begin
         rsp_in.last = 1'b1;
         rsp_in.item_value = req_ff.value;
         unique case (req_ff.action)
            sle_pkg::ACT_INSERT:
               rsp_in.status = (count_ff == sle_pkg::CntWidth'(sle_pkg::Capacity)) ?
                               sle_pkg::ST_FULL : sle_pkg::ST_OK;
            sle_pkg::ACT_REMOVE, sle_pkg::ACT_SEARCH:
               rsp_in.status = (|eq_v) ? sle_pkg::ST_OK : sle_pkg::ST_NOTFOUND;
            default: begin
               rsp_in.status = sle_pkg::ST_EMPTY;
               rsp_in.item_value = '0;
            end
         endcase
      end else if (cmd.load_dump) begin
         rsp_in.status = sle_pkg::ST_OK;
         rsp_in.item_value = cell_ff[src_idx];
         rsp_in.last = (didx_ff == last_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < sle_pkg::Capacity; i++) cell_ff[i] <= cell_in[i];
      if (cmd.latch_req) req_ff <= req_data;
      didx_ff <= didx_in;
      rsp_ff <= rsp_in;
   end

   assign stat.action    = req_ff.action;
   assign stat.full      = (count_ff == sle_pkg::CntWidth'(sle_pkg::Capacity));
   assign stat.empty     = (count_ff == '0);
   assign stat.found     = |eq_v;
   assign stat.dump_last = (didx_ff == last_idx);
   assign rsp_data       = rsp_ff;

endmodule

// ----- hdl/sle_control.sv -----
// Controller state machine for the sorted list engine.
module sle_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sle_pkg::sle_stat_type stat,
   output sle_pkg::sle_cmd_type  cmd
);

   sle_pkg::state_type state_ff, state_in;
   logic from_dump_ff, from_dump_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sle_pkg::S_IDLE;
         from_dump_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         from_dump_ff <= from_dump_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      from_dump_in = from_dump_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         sle_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in = sle_pkg::S_EXEC;
            end
         end
         sle_pkg::S_EXEC: begin
            from_dump_in = 1'b0;
            unique case (stat.action)
               sle_pkg::ACT_INSERT: begin
                  cmd.do_insert   = !stat.full;
                  cmd.load_single = 1'b1;
                  state_in = sle_pkg::S_SEND;
               end
               sle_pkg::ACT_REMOVE: begin
                  cmd.do_remove   = stat.found;
                  cmd.load_single = 1'b1;
                  state_in = sle_pkg::S_SEND;
               end
               sle_pkg::ACT_SEARCH: begin
                  cmd.load_single = 1'b1;
                  state_in = sle_pkg::S_SEND;
               end
               sle_pkg::ACT_DUMP_ASC, sle_pkg::ACT_DUMP_DSC: begin
                  if (stat.empty) begin
                     cmd.load_single = 1'b1;
                     state_in = sle_pkg::S_SEND;
                  end else begin
                     cmd.dump_start = 1'b1;
                     state_in = sle_pkg::S_DUMP;
                  end
               end
               default: state_in = sle_pkg::S_IDLE;
            endcase
         end
         sle_pkg::S_DUMP: begin
            cmd.load_dump = 1'b1;
            from_dump_in  = !stat.dump_last;
            cmd.dump_step = 1'b1;
            state_in = sle_pkg::S_SEND;
         end
         sle_pkg::S_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready)
               state_in = from_dump_ff ? sle_pkg::S_DUMP : sle_pkg::S_IDLE;
         end
         default: state_in = sle_pkg::S_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (cmd.do_insert |-> !stat.full)) else $error("insert into full list");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.do_remove |-> stat.found)) else $error("remove without match");
   assert property (@(posedge clock) disable iff (reset)
      (req_ready |-> !rsp_valid)) else $error("accept during result hold");

endmodule

// ----- hdl/sorted_list_engine.sv -----
// Top level of the sorted list engine.
// Keeps up to sle_pkg::Capacity signed 32-bit values in ascending order in a
// chain of entry cells. Insert, remove and search compare all cells in
// parallel; the execute state commits the shift and registers the result,
// which the send state offers for transfer. A dump emits one result per
// entry, read in the dump state, then transferred in the send state. An
// empty dump gives a single status-3 result. Codes 5 to 7 produce no result.
// Items are taken one at a time; req_ready is high only in the idle state.
module sorted_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sle_pkg::rsp_type rsp_data
);

   sle_pkg::sle_cmd_type  cmd;
   sle_pkg::sle_stat_type stat;

   sle_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   sle_datapath u_dp (
      .clock, .reset, .req_data, .cmd, .stat, .rsp_data
   );

endmodule

// ----- sim/sorted_list_engine_test.sv -----
// Testbench for the sorted list engine: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module sorted_list_engine_test;

   localparam int WatchdogLimit = 20000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   sle_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   sle_pkg::rsp_type rsp_data;

   // Predictor state: sorted copy of the list.
   logic signed [31:0] list_model[$];
   // Expected results, oldest first.
   sle_pkg::rsp_type   pending_rsps[$];
   int                 error_count;
   int                 idle_cycles;
   int                 rsp_wait;   // receiver cycles left before ready
   bit                 hold_rsp;   // long receiver hold-off when set
   bit                 no_rsp_gaps;

   sorted_list_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic sle_pkg::rsp_type make_rsp(logic [1:0] st, logic signed [31:0] val,
                                                 int cnt, bit lst);
      sle_pkg::rsp_type r;
      r.status      = st;
      r.item_value  = val;
      r.entry_count = cnt[4:0];
      r.last        = lst;
      return r;
   endfunction

   // Apply one request to the list copy and queue the results it causes.
   task automatic predict_list_op(sle_pkg::req_type rq);
      int pos;
      int idx;
      int n;
      pos = 0;
      idx = -1;
      n   = list_model.size();
      for (int i = 0; i < n; i++)
         if (idx < 0 && list_model[i] == rq.value) idx = i;
      case (rq.action)
         sle_pkg::ACT_INSERT: begin
            if (n >= sle_pkg::Capacity) begin
               pending_rsps.push_back(make_rsp(sle_pkg::ST_FULL, rq.value, n, 1'b1));
            end else begin
               while (pos < n && rq.value > list_model[pos]) pos++;
               list_model.insert(pos, rq.value);
               pending_rsps.push_back(make_rsp(sle_pkg::ST_OK, rq.value, n + 1, 1'b1));
            end
         end
         sle_pkg::ACT_REMOVE: begin
            if (idx < 0) begin
               pending_rsps.push_back(make_rsp(sle_pkg::ST_NOTFOUND, rq.value, n, 1'b1));
            end else begin
               list_model.delete(idx);
               pending_rsps.push_back(make_rsp(sle_pkg::ST_OK, rq.value, n - 1, 1'b1));
            end
         end
         sle_pkg::ACT_SEARCH: begin
            pending_rsps.push_back(make_rsp(idx < 0 ? sle_pkg::ST_NOTFOUND : sle_pkg::ST_OK,
                                            rq.value, n, 1'b1));
         end
         sle_pkg::ACT_DUMP_ASC, sle_pkg::ACT_DUMP_DSC: begin
            if (n == 0) begin
               pending_rsps.push_back(make_rsp(sle_pkg::ST_EMPTY, 32'sd0, 0, 1'b1));
            end else begin
               for (int i = 0; i < n; i++)
                  pending_rsps.push_back(make_rsp(sle_pkg::ST_OK,
                     list_model[rq.action == sle_pkg::ACT_DUMP_ASC ? i : n - 1 - i], n,
                     i == n - 1));
            end
         end
         default: ;  // unused codes: no result
      endcase
   endtask

   // Send one item after a randomly drawn idle gap, then wait until it is accepted.
   task automatic send_req(logic [2:0] act, logic signed [31:0] val);
      sle_pkg::req_type rq;
      int gap;
      rq.action = act;
      rq.value  = val;
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      predict_list_op(rq);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Values drawn mostly from a small pool so duplicates and hits are common.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return $urandom;
         1:       return 32'sh7fffffff;
         2:       return 32'sh80000000;
         default: return $signed($urandom_range(0, 12)) - 6;
      endcase
   endfunction

   // Receiver: draws a random wait after each result, or a long hold-off when requested.
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         w = no_rsp_gaps ? 0 : $urandom_range(0, 10);
         rsp_ready <= (w == 0);
         rsp_wait  <= (w > 0) ? w - 1 : 0;
      end else if (!rsp_ready) begin
         if (rsp_wait == 0)
            rsp_ready <= 1'b1;
         else
            rsp_wait <= rsp_wait - 1;
      end
   end

   // Result checker: each transfer against the oldest expectation.
   always @(posedge clock) begin
      sle_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            error_count++;
         end else begin
            exp_rsp = pending_rsps.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_rsp.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.item_value !== exp_rsp.item_value) begin
               $display("%0t: item_value expected %0d actual %0d", $time,
                        exp_rsp.item_value, rsp_data.item_value);
               error_count++;
            end
            if (rsp_data.entry_count !== exp_rsp.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d", $time,
                        exp_rsp.entry_count, rsp_data.entry_count);
               error_count++;
            end
            if (rsp_data.last !== exp_rsp.last) begin
               $display("%0t: last expected %0d actual %0d", $time,
                        exp_rsp.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   // Watchdog: cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // Empty list: dumps, misses and unused codes, then extremes and equal values, searches, dumps and removes.
   task automatic test_directed();
      send_req(sle_pkg::ACT_DUMP_ASC, 32'sd5);
      send_req(sle_pkg::ACT_DUMP_DSC, 32'sd0);
      send_req(sle_pkg::ACT_REMOVE, 32'sd1);
      send_req(sle_pkg::ACT_SEARCH, -32'sd1);
      send_req(3'd5, 32'sd9);
      send_req(3'd6, 32'sd9);
      send_req(3'd7, -32'sd1);
      send_req(sle_pkg::ACT_INSERT, 32'sh7fffffff);
      send_req(sle_pkg::ACT_INSERT, 32'sh80000000);
      send_req(sle_pkg::ACT_INSERT, 32'sd0);
      send_req(sle_pkg::ACT_INSERT, 32'sd0);
      send_req(sle_pkg::ACT_INSERT, -32'sd1);
      send_req(sle_pkg::ACT_INSERT, 32'sh55555555);
      send_req(sle_pkg::ACT_INSERT, 32'shaaaaaaaa);
      send_req(sle_pkg::ACT_SEARCH, 32'sd0);
      send_req(sle_pkg::ACT_SEARCH, 32'sd7);
      send_req(sle_pkg::ACT_DUMP_ASC, 32'sd0);
      send_req(sle_pkg::ACT_DUMP_DSC, 32'sd0);
      send_req(sle_pkg::ACT_REMOVE, 32'sd0);
      send_req(sle_pkg::ACT_REMOVE, 32'sh80000000);
      send_req(sle_pkg::ACT_REMOVE, 32'sh7fffffff);
      send_req(sle_pkg::ACT_DUMP_ASC, 32'sd0);
   endtask

   // Fill to capacity behind a held receiver, then overflow and dump both ways.
   task automatic test_full_list();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            while (list_model.size() < sle_pkg::Capacity)
               send_req(sle_pkg::ACT_INSERT, pick_value());
            req_valid <= 1'b0;
         end
      join
      send_req(sle_pkg::ACT_INSERT, 32'sd3);
      send_req(sle_pkg::ACT_INSERT, 32'sh80000000);
      send_req(sle_pkg::ACT_DUMP_DSC, 32'sd0);
      send_req(sle_pkg::ACT_DUMP_ASC, 32'sd0);
      wait_drained();
   endtask

   // Random mix weighted toward inserts so the list grows and shrinks.
   task automatic test_random_ops();
      int sel;
      for (int i = 0; i < 90; i++) begin
         no_rsp_gaps = (i >= 40 && i < 55);
         sel = $urandom_range(0, 19);
         if (sel < 8)       send_req(sle_pkg::ACT_INSERT, pick_value());
         else if (sel < 13) send_req(sle_pkg::ACT_REMOVE, pick_value());
         else if (sel < 16) send_req(sle_pkg::ACT_SEARCH, pick_value());
         else if (sel < 18) send_req(sle_pkg::ACT_DUMP_ASC + 3'(sel - 16), $urandom);
         else if (sel < 19) send_req(3'($urandom_range(5, 7)), $urandom);
         else               send_req(sle_pkg::ACT_REMOVE,
                                     list_model.size() ? list_model[0] : 0);
      end
      no_rsp_gaps = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      error_count = 0;
      idle_cycles = 0;
      hold_rsp    = 1'b0;
      no_rsp_gaps = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_drained();  // sender pauses until every result is in
      test_full_list();
      test_random_ops();
      wait_drained();
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
